// ===== sv/svpi_pkg.sv =====
// shared types, register codes and the control program of the
// smoothed velocity and position integrator; no dependencies
package svpi_pkg;

	localparam int unsigned StepW = 5;

	typedef enum logic [2:0] {
		REG_MIN_X     = 3'd0,
		REG_MAX_X     = 3'd1,
		REG_MIN_Y     = 3'd2,
		REG_MAX_Y     = 3'd3,
		REG_MIN_Z     = 3'd4,
		REG_MAX_Z     = 3'd5,
		REG_GAIN      = 3'd6,
		REG_STEP_LEN  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_START,
		OP_SMUL,
		OP_SADD,
		OP_IMUL,
		OP_IADD,
		OP_CLAMP,
		OP_HADD,
		OP_RESTART,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_RESTART,
		COND_ALWAYS
	} cond_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		op_t              op;
		logic [1:0]       axis;
		cond_t            cond;
		logic [StepW-1:0] target;
	} ucode_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic       tgt_we;
	} dp_ctrl_t;

	localparam logic [1:0] AX_X   = 2'd0;
	localparam logic [1:0] AX_Y   = 2'd1;
	localparam logic [1:0] AX_Z   = 2'd2;
	localparam logic [1:0] AX_YAW = 2'd3;

	localparam logic [StepW-1:0] STEP_RESTART = 5'd20;
	localparam logic [StepW-1:0] STEP_EMIT    = 5'd21;
	localparam logic [StepW-1:0] LAST_STEP    = 5'd21;
	localparam logic [StepW-1:0] STEP_NONE    = 5'd0;

	// control store: smoothing of all four rates, then integration of all four and clamp of x, y and z
	function automatic ucode_t ucode(input logic [StepW-1:0] step);
		ucode_t w;
		w = '{op: OP_EMIT, axis: AX_X, cond: COND_NONE, target: STEP_NONE};
		case (step)
			5'd0:  w = '{OP_START,   AX_X,   COND_RESTART, STEP_RESTART};
			5'd1:  w = '{OP_SMUL,    AX_X,   COND_NONE,    STEP_NONE};
			5'd2:  w = '{OP_SADD,    AX_X,   COND_NONE,    STEP_NONE};
			5'd3:  w = '{OP_SMUL,    AX_Y,   COND_NONE,    STEP_NONE};
			5'd4:  w = '{OP_SADD,    AX_Y,   COND_NONE,    STEP_NONE};
			5'd5:  w = '{OP_SMUL,    AX_Z,   COND_NONE,    STEP_NONE};
			5'd6:  w = '{OP_SADD,    AX_Z,   COND_NONE,    STEP_NONE};
			5'd7:  w = '{OP_SMUL,    AX_YAW, COND_NONE,    STEP_NONE};
			5'd8:  w = '{OP_SADD,    AX_YAW, COND_NONE,    STEP_NONE};
			5'd9:  w = '{OP_IMUL,    AX_X,   COND_NONE,    STEP_NONE};
			5'd10: w = '{OP_IADD,    AX_X,   COND_NONE,    STEP_NONE};
			5'd11: w = '{OP_CLAMP,   AX_X,   COND_NONE,    STEP_NONE};
			5'd12: w = '{OP_IMUL,    AX_Y,   COND_NONE,    STEP_NONE};
			5'd13: w = '{OP_IADD,    AX_Y,   COND_NONE,    STEP_NONE};
			5'd14: w = '{OP_CLAMP,   AX_Y,   COND_NONE,    STEP_NONE};
			5'd15: w = '{OP_IMUL,    AX_Z,   COND_NONE,    STEP_NONE};
			5'd16: w = '{OP_IADD,    AX_Z,   COND_NONE,    STEP_NONE};
			5'd17: w = '{OP_CLAMP,   AX_Z,   COND_NONE,    STEP_NONE};
			5'd18: w = '{OP_IMUL,    AX_YAW, COND_NONE,    STEP_NONE};
			5'd19: w = '{OP_HADD,    AX_YAW, COND_ALWAYS,  STEP_EMIT};
			5'd20: w = '{OP_RESTART, AX_X,   COND_NONE,    STEP_NONE};
			5'd21: w = '{OP_EMIT,    AX_X,   COND_NONE,    STEP_NONE};
			default: w = '{OP_EMIT,  AX_X,   COND_NONE,    STEP_NONE};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/svpi_dpath.sv =====
// datapath of the integrator: motion state, held targets, a smoothing and an
// integration multiplier sharing one product register; depends on svpi_pkg
module svpi_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  svpi_pkg::dp_ctrl_t    ctrl,
	input  logic [3:0][15:0]      tgt_in,
	input  logic [2:0][23:0]      box_min,
	input  logic [2:0][23:0]      box_max,
	input  logic [8:0]            gain,
	input  logic [16:0]           dt,
	output logic [2:0][39:0]      pos,
	output logic [2:0][23:0]      vel,
	output logic [47:0]           hdg,
	output logic [23:0]           rate
);

	logic [2:0][39:0] p_q;
	logic [2:0][23:0] v_q;
	logic [47:0]      hacc_q;
	logic [23:0]      hrate_q;
	logic [3:0][15:0] tgt_q;
	logic signed [41:0] prod_s1;
	logic signed [41:0] psum_q;

	logic signed [23:0] vsel;
	logic signed [39:0] psel;
	logic [23:0]        bmin;
	logic [23:0]        bmax;
	logic [15:0]        tsel;
	logic signed [24:0] diff;
	logic signed [9:0]  gain_s;
	logic signed [17:0] dt_s;
	logic signed [34:0] smul;
	logic signed [41:0] imul;
	logic signed [41:0] prod_sh;
	logic [23:0]        vnew;
	logic signed [41:0] psum_n;
	logic signed [41:0] lo42;
	logic signed [41:0] hi42;
	logic               lo_hit;
	logic               hi_hit;
	logic signed [41:0] lo_fix;
	logic [39:0]        pclamp;
	logic [2:0][39:0]   pmid;

	always_comb begin
		case (ctrl.axis)
			svpi_pkg::AX_X: begin
				vsel = $signed(v_q[0]);
				psel = $signed(p_q[0]);
				bmin = box_min[0];
				bmax = box_max[0];
			end
			svpi_pkg::AX_Y: begin
				vsel = $signed(v_q[1]);
				psel = $signed(p_q[1]);
				bmin = box_min[1];
				bmax = box_max[1];
			end
			svpi_pkg::AX_Z: begin
				vsel = $signed(v_q[2]);
				psel = $signed(p_q[2]);
				bmin = box_min[2];
				bmax = box_max[2];
			end
			default: begin
				vsel = $signed(hrate_q);
				psel = $signed(p_q[2]);
				bmin = box_min[2];
				bmax = box_max[2];
			end
		endcase
	end

	assign tsel = tgt_q[ctrl.axis];

	// gain of 256 and above means the target is taken at once
	assign gain_s = $signed({1'b0, (gain[8] ? 9'd256 : gain)});
	assign dt_s   = $signed({1'b0, dt});
	assign diff   = $signed({tsel[15], tsel, 8'b0}) - $signed({vsel[23], vsel});
	assign smul   = diff * gain_s;
	assign imul   = vsel * dt_s;

	assign prod_sh = prod_s1 >>> 8;
	assign vnew    = vsel + prod_sh[23:0];
	assign psum_n  = 42'(psel) + prod_sh;

	assign lo42   = $signed({{2{bmin[23]}}, bmin, 16'b0});
	assign hi42   = $signed({{2{bmax[23]}}, bmax, 16'b0});
	// min test first, then max test on what it left
	assign lo_hit = psum_q < lo42;
	assign lo_fix = lo_hit ? lo42 : psum_q;
	assign hi_hit = lo_fix > hi42;
	assign pclamp = hi_hit ? hi42[39:0] : lo_fix[39:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pmid[i] = {25'($signed({box_min[i][23], box_min[i]})
				+ $signed({box_max[i][23], box_max[i]})), 15'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= '0;
			v_q     <= '0;
			hacc_q  <= '0;
			hrate_q <= '0;
			tgt_q   <= '0;
		end else begin
			if (ctrl.tgt_we) begin
				tgt_q <= tgt_in;
			end
			case (ctrl.op)
				svpi_pkg::OP_SADD: begin
					if (ctrl.axis == svpi_pkg::AX_YAW) begin
						hrate_q <= vnew;
					end else begin
						v_q[ctrl.axis] <= vnew;
					end
				end
				svpi_pkg::OP_CLAMP: begin
					p_q[ctrl.axis] <= pclamp;
					if (lo_hit || hi_hit) begin
						v_q[ctrl.axis] <= '0;
					end
				end
				svpi_pkg::OP_HADD: begin
					hacc_q <= hacc_q + 48'(prod_sh);
				end
				svpi_pkg::OP_RESTART: begin
					p_q     <= pmid;
					v_q     <= '0;
					hacc_q  <= '0;
					hrate_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// shared multiplier result and position sum
	always_ff @(posedge clk) begin
		case (ctrl.op)
			svpi_pkg::OP_SMUL: prod_s1 <= 42'(smul);
			svpi_pkg::OP_IMUL: prod_s1 <= imul;
			svpi_pkg::OP_IADD: psum_q  <= psum_n;
			default: begin
			end
		endcase
	end

	assign pos  = p_q;
	assign vel  = v_q;
	assign hdg  = hacc_q;
	assign rate = hrate_q;

endmodule

// ===== sv/smoothed_velocity_position_integrator.sv =====
// top level of the smoothed velocity and position integrator: register
// port, microcoded sequencer and result register; uses svpi_pkg, svpi_dpath
//
// usage: every beat on the slave stream is one physics tick. s_tuser[0] set
// latches the four targets in s_tdata, s_tuser[1] set restarts the motion
// state at the box midpoint. each tick gives one result beat on the master
// stream with position, velocity, heading and yaw rate.
// a tick is run by a 22-step control program driving the smoothing and
// integration multipliers: four smoothing steps (multiply, add), then four
// integration steps (multiply, add, and a clamp for x, y and z). m_tvalid
// is set by the emit step and the sequencer goes idle; no new tick is
// taken while one is computed. the steps over the four axes set the tick length.
// the result sits in an output register; while it waits the next tick is
// taken and computed, and the program holds on its last step until the
// register frees up.
// reset clears motion state and targets and loads the register defaults
// (box 0 to 10000 mm, gain 51, step 655). registers are to be written via
// apb only while no tick is in flight; the block does not enforce this.
module smoothed_velocity_position_integrator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// target_vx, target_vy, target_vz, target_turn_rate
	input  logic [63:0]   s_tdata,
	// new_command, restart
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, heading, turn_rate
	output logic [167:0]  m_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic [2:0][23:0] box_min_q;
	logic [2:0][23:0] box_max_q;
	logic [8:0]       gain_q;
	logic [16:0]      step_len_q;

	svpi_pkg::seq_state_t          state_q, state_d;
	logic [svpi_pkg::StepW-1:0]    step_q, step_d;
	logic                          restart_q;
	svpi_pkg::ucode_t              word;
	svpi_pkg::dp_ctrl_t            ctrl;
	logic                          in_fire;
	logic                          emit_fire;
	logic                          jump;

	logic [167:0]     m_tdata_q;
	logic             m_tvalid_q;
	logic [2:0][39:0] pos;
	logic [2:0][23:0] vel;
	logic [47:0]      hdg;
	logic [23:0]      rate;
	logic             wr_en;
	svpi_pkg::reg_idx_t wr_idx;
	svpi_pkg::reg_idx_t rd_idx;

	// register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_idx = svpi_pkg::reg_idx_t'(paddr[4:2]);
	assign rd_idx = svpi_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q  <= '0;
			box_max_q  <= {3{24'd10000}};
			gain_q     <= 9'd51;
			step_len_q <= 17'd655;
		end else if (wr_en) begin
			case (wr_idx)
				svpi_pkg::REG_MIN_X:    box_min_q[0] <= pwdata[23:0];
				svpi_pkg::REG_MAX_X:    box_max_q[0] <= pwdata[23:0];
				svpi_pkg::REG_MIN_Y:    box_min_q[1] <= pwdata[23:0];
				svpi_pkg::REG_MAX_Y:    box_max_q[1] <= pwdata[23:0];
				svpi_pkg::REG_MIN_Z:    box_min_q[2] <= pwdata[23:0];
				svpi_pkg::REG_MAX_Z:    box_max_q[2] <= pwdata[23:0];
				svpi_pkg::REG_GAIN:     gain_q       <= pwdata[8:0];
				svpi_pkg::REG_STEP_LEN: step_len_q   <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			svpi_pkg::REG_MIN_X:    prdata = 32'($signed(box_min_q[0]));
			svpi_pkg::REG_MAX_X:    prdata = 32'($signed(box_max_q[0]));
			svpi_pkg::REG_MIN_Y:    prdata = 32'($signed(box_min_q[1]));
			svpi_pkg::REG_MAX_Y:    prdata = 32'($signed(box_max_q[1]));
			svpi_pkg::REG_MIN_Z:    prdata = 32'($signed(box_min_q[2]));
			svpi_pkg::REG_MAX_Z:    prdata = 32'($signed(box_max_q[2]));
			svpi_pkg::REG_GAIN:     prdata = {23'b0, gain_q};
			svpi_pkg::REG_STEP_LEN: prdata = {15'b0, step_len_q};
			default:                prdata = '0;
		endcase
	end

	// sequencer
	assign s_tready = (state_q == svpi_pkg::SEQ_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign word     = svpi_pkg::ucode(step_q);
	assign jump     = (word.cond == svpi_pkg::COND_ALWAYS)
		|| ((word.cond == svpi_pkg::COND_RESTART) && restart_q);

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		emit_fire = 1'b0;
		ctrl      = '{op: svpi_pkg::OP_NOP, axis: svpi_pkg::AX_X, tgt_we: 1'b0};
		case (state_q)
			svpi_pkg::SEQ_IDLE: begin
				step_d      = '0;
				ctrl.tgt_we = in_fire && s_tuser[0];
				if (in_fire) begin
					state_d = svpi_pkg::SEQ_RUN;
				end
			end
			svpi_pkg::SEQ_RUN: begin
				ctrl.axis = word.axis;
				if (word.op == svpi_pkg::OP_EMIT) begin
					// hold on the last step while the result register is full
					if (!m_tvalid_q || m_tready) begin
						emit_fire = 1'b1;
						state_d   = svpi_pkg::SEQ_IDLE;
						step_d    = '0;
					end
				end else begin
					ctrl.op = word.op;
					step_d  = jump ? word.target : step_q + 1'b1;
				end
			end
			default: begin
				state_d = svpi_pkg::SEQ_IDLE;
				step_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svpi_pkg::SEQ_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			restart_q <= s_tuser[1];
		end
	end

	svpi_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.tgt_in  ({s_tdata[63:48], s_tdata[47:32], s_tdata[31:16], s_tdata[15:0]}),
		.box_min (box_min_q),
		.box_max (box_max_q),
		.gain    (gain_q),
		.dt      (step_len_q),
		.pos     (pos),
		.vel     (vel),
		.hdg     (hdg),
		.rate    (rate)
	);

	// result register: whole units, fraction dropped toward minus infinity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {rate[23:8], hdg[47:16], vel[2][23:8], vel[1][23:8],
				vel[0][23:8], pos[2][39:16], pos[1][39:16], pos[0][39:16]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == svpi_pkg::SEQ_RUN) && (step_q == '0))
		else $error("tick taken but program did not start at step zero");

	a_idle_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svpi_pkg::SEQ_IDLE) |-> (step_q == '0))
		else $error("step counter not parked while idle");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svpi_pkg::SEQ_RUN) |-> (step_q <= svpi_pkg::LAST_STEP))
		else $error("step counter ran past the program");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> m_tvalid)
		else $error("result emitted but output not valid");
`endif

endmodule
